// ===== rtl/sfd_pkg.sv =====
package sfd_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned FracBits  = 23;
  localparam int unsigned MantWidth = 24;
  localparam int unsigned ExpWidth  = 8;
  localparam int unsigned QuotSteps = 24;
  localparam int unsigned StepsPerStage = 4;

  localparam logic [ExpWidth+1:0] ExpBias      = 10'd127;
  localparam logic [ExpWidth+1:0] ExpMaxFinite = 10'd254;
  localparam logic [WordWidth-1:0] SignMask    = 32'h8000_0000;

  // Per-item metadata carried along the pipeline.
  typedef struct packed {
    logic                   zero_pass;
    logic [WordWidth-1:0]   passthru;
    logic                   sign;
    logic [ExpWidth+1:0]    exp;
    logic [MantWidth-1:0]   den;
  } sfd_meta_t;

endpackage

// ===== rtl/sfd_if.sv =====
interface sfd_in_if;
  logic                              valid;
  logic                              ready;
  logic [sfd_pkg::WordWidth-1:0]     dividend;
  logic [sfd_pkg::WordWidth-1:0]     divisor;
  modport source (output valid, dividend, divisor, input ready);
  modport sink   (input valid, dividend, divisor, output ready);
endinterface

interface sfd_out_if;
  logic                              valid;
  logic                              ready;
  logic [sfd_pkg::WordWidth-1:0]     quotient;
  modport source (output valid, quotient, input ready);
  modport sink   (input valid, quotient, output ready);
endinterface

// ===== rtl/single_float_divider.sv =====
// Channel   Direction  Payload
// in_ch     sink       dividend[31:0], divisor[31:0]
// out_ch    source     quotient[31:0]
//
// The block accepts one transaction per cycle while the output is not stalled.
// It has one unpack stage, six restoring-division stages of four quotient
// bits each, and one normalize/pack stage that also serves as the output register.
// Reset (synchronous, active high) clears only the valid bits.
// When the output is stalled the entire pipeline holds; ready follows
// the output side, so no transaction is dropped or repeated.
module single_float_divider (
  input logic clk,
  input logic rst,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch
);

  localparam int unsigned DivStages = sfd_pkg::QuotSteps / sfd_pkg::StepsPerStage;
  localparam int unsigned NStages   = DivStages + 2;
  localparam int unsigned MW        = sfd_pkg::MantWidth;

  // The remainder never exceeds twice the divisor, so MW+1 bits suffice.
  logic                    vld  [NStages];
  sfd_pkg::sfd_meta_t      meta [DivStages+1];
  logic [MW:0]             rem  [DivStages+1];
  logic [MW-1:0]           quo  [DivStages+1];
  logic [sfd_pkg::WordWidth-1:0] quotient;
  logic                    adv;

  assign adv          = !vld[NStages-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld[NStages-1];
  assign out_ch.quotient = quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NStages; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_ch.valid;
      for (int i = 1; i < NStages; i++) vld[i] <= vld[i-1];
    end
  end

  // Unpack stage. The first quotient bit compares ma<<23 against mb<<23,
  // i.e. ma against mb, so the remainder starts as the dividend mantissa.
  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0].zero_pass <= (in_ch.dividend[sfd_pkg::WordWidth-2:0] == '0);
      meta[0].passthru  <= in_ch.dividend;
      meta[0].sign      <= in_ch.dividend[sfd_pkg::WordWidth-1] ^
                           in_ch.divisor[sfd_pkg::WordWidth-1];
      meta[0].exp       <= {2'b00, in_ch.dividend[30:23]} -
                           {2'b00, in_ch.divisor[30:23]} + sfd_pkg::ExpBias;
      meta[0].den       <= {1'b1, in_ch.divisor[sfd_pkg::FracBits-1:0]};
      rem[0]            <= {2'b01, in_ch.dividend[sfd_pkg::FracBits-1:0]};
      quo[0]            <= '0;
    end
  end

  // Restoring division: each stage resolves four quotient bits.
  for (genvar s = 0; s < DivStages; s++) begin : g_div
    logic [MW:0]   r_w [sfd_pkg::StepsPerStage+1];
    logic [MW-1:0] q_w [sfd_pkg::StepsPerStage+1];
    logic [MW+1:0] diff;
    always_comb begin
      r_w[0] = rem[s];
      q_w[0] = quo[s];
      diff   = '0;
      for (int k = 0; k < sfd_pkg::StepsPerStage; k++) begin
        diff = {1'b0, r_w[k]} - {2'b00, meta[s].den};
        if (!diff[MW+1]) begin
          r_w[k+1] = {diff[MW-1:0], 1'b0};
          q_w[k+1] = {q_w[k][MW-2:0], 1'b1};
        end else begin
          r_w[k+1] = {r_w[k][MW-1:0], 1'b0};
          q_w[k+1] = {q_w[k][MW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        meta[s+1] <= meta[s];
        rem[s+1]  <= r_w[sfd_pkg::StepsPerStage];
        quo[s+1]  <= q_w[sfd_pkg::StepsPerStage];
      end
    end
  end

  // Normalize, flush or saturate, pass zero dividends through, and pack into the output register.
  logic [MW-1:0]  mq;
  logic [9:0]     eq;
  sfd_pkg::sfd_meta_t mf;
  logic [sfd_pkg::WordWidth-1:0] packed_w;

  always_comb begin
    mf = meta[DivStages];
    mq = quo[DivStages];
    eq = mf.exp;
    if (!mq[sfd_pkg::FracBits]) begin
      mq = {mq[MW-2:0], 1'b0};
      eq = eq - 10'd1;
    end
    // A negative exponent shows as bit 9 set.
    if (eq[9] || eq == '0) begin
      packed_w = {mf.sign, 31'd0};
    end else if (eq > sfd_pkg::ExpMaxFinite) begin
      packed_w = {mf.sign, 31'h7F7F_FFFF};
    end else begin
      packed_w = {mf.sign, eq[7:0], mq[sfd_pkg::FracBits-1:0]};
    end
    if (mf.zero_pass) packed_w = mf.passthru;
  end

  always_ff @(posedge clk) begin
    if (adv) quotient <= packed_w;
  end

endmodule

// ===== verif/sfd_tb_if.sv =====
package sfd_tb_pkg;

  typedef struct packed {
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_operands_t;

endpackage

// ===== verif/tb_single_float_divider.sv =====
module tb_single_float_divider;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeLatency   = 8;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk;
  logic rst;

  sfd_in_if  in_ch ();
  sfd_out_if out_ch ();

  single_float_divider dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Free-running clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Operand pairs waiting to be offered, and quotients that the block owes us.
  sfd_tb_pkg::div_operands_t pending_ops[$];
  logic [31:0]   owed_quotients[$];

  int unsigned error_count;
  int unsigned idle_cycles;
  bit          hold_sender;
  bit          long_stall_req;
  bit          long_stall_taken;
  int unsigned send_gap;
  int unsigned recv_gap;

  // Computes the truncated quotient exactly as the block does. The mantissa
  // division is a plain 24-step restoring division with the hidden bits forced
  // to one, so the divisor mantissa is never zero.
  function automatic logic [31:0] truncated_quotient(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] rem;
    logic [47:0] trial;
    logic [23:0] mq;
    int          eq;
    sgn = a[31] ^ b[31];
    if (a[30:0] == '0) begin
      return a;
    end
    ma  = {1'b1, a[22:0]};
    mb  = {1'b1, b[22:0]};
    eq  = int'(a[30:23]) - int'(b[30:23]) + 127;
    rem = {1'b0, ma, 23'd0};
    mq  = '0;
    for (int step = 23; step >= 0; step--) begin
      trial = 48'(mb) << step;
      mq    = mq << 1;
      if (rem >= trial) begin
        rem   = rem - trial;
        mq[0] = 1'b1;
      end
    end
    // A single normalize step when the leading quotient bit is clear.
    if (!mq[23]) begin
      mq = mq << 1;
      eq = eq - 1;
    end
    if (eq < 1) begin
      return {sgn, 31'd0};
    end else if (eq > 254) begin
      return {sgn, 8'd254, 23'h7f_ffff};
    end
    return {sgn, eq[7:0], mq[22:0]};
  endfunction

  // Mostly no gap at all, often a short one, and sometimes a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Builds a float from its fields.
  function automatic logic [31:0] pack_float(logic s, logic [7:0] e, logic [22:0] f);
    return {s, e, f};
  endfunction

  // Random operand pair. Exponents are kept mostly near each other so the
  // mantissa datapath is exercised, with a share of signed zero dividends and
  // a share of fully random words that reach flushing and saturation.
  function automatic sfd_tb_pkg::div_operands_t random_operands();
    sfd_tb_pkg::div_operands_t op;
    int unsigned   roll;
    logic [7:0]    ea;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      op.dividend = $urandom();
      op.divisor  = $urandom();
    end else if (roll < 25) begin
      op.dividend = {$urandom_range(0, 1) == 1, 31'd0};
      op.divisor  = $urandom();
    end else begin
      ea          = 8'($urandom_range(0, 255));
      op.dividend = pack_float(1'($urandom_range(0, 1)), ea, 23'($urandom()));
      op.divisor  = pack_float(1'($urandom_range(0, 1)),
                               8'(int'(ea) + $urandom_range(0, 40) - 20),
                               23'($urandom()));
    end
    return op;
  endfunction

  // Driver: offers the head of the pending queue. A transaction completes on
  // an edge where valid and ready are both high; valid is only changed once
  // per edge so a back-to-back item never sees a spurious low.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid    <= 1'b0;
      in_ch.dividend <= '0;
      in_ch.divisor  <= '0;
      send_gap       <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        owed_quotients.push_back(truncated_quotient(in_ch.dividend, in_ch.divisor));
        void'(pending_ops.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Keep offering the same transaction.
      end else if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_ops.size() != 0 && !hold_sender) begin
        // With a gap drawn, valid drops after this single transaction.
        in_ch.valid    <= 1'b1;
        in_ch.dividend <= pending_ops[0].dividend;
        in_ch.divisor  <= pending_ops[0].divisor;
        send_gap       <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver: compares each quotient with the oldest one owed and
  // draws random back-pressure, including one long hold-off on request.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      out_ch.ready     <= 1'b0;
      recv_gap         <= 0;
      long_stall_taken <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_quotients.size() == 0) begin
          $error("quotient: unexpected transaction, actual %h", out_ch.quotient);
          error_count++;
        end else begin
          want = owed_quotients.pop_front();
          if (out_ch.quotient !== want) begin
            $error("quotient: expected %h, actual %h", want, out_ch.quotient);
            error_count++;
          end
        end
      end
      if (long_stall_req && !long_stall_taken) begin
        recv_gap         <= 200;
        long_stall_taken <= 1'b1;
        out_ch.ready     <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap     <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap     <= pick_gap();
      end
    end
  end

  // Watchdog: counts cycles without any accepted transaction.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic wait_for_drain();
    while (pending_ops.size() != 0 || owed_quotients.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    error_count    = 0;
    hold_sender    = 1'b0;
    long_stall_req = 1'b0;
    rst            = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed transactions: signed zeros pass through, extreme exponents and
    // fractions, unit divisor, exponent flush and saturation, and operands
    // with exponent fields of zero and 255.
    pending_ops.push_back('{32'h0000_0000, 32'h3f80_0000});
    pending_ops.push_back('{32'h8000_0000, 32'hc000_0000});
    pending_ops.push_back('{32'h0000_0000, 32'h0000_0000});
    pending_ops.push_back('{32'h3f80_0000, 32'h3f80_0000});
    pending_ops.push_back('{32'h3f80_0000, 32'h4040_0000});
    pending_ops.push_back('{32'hbfff_ffff, 32'h3f80_0000});
    pending_ops.push_back('{32'h4000_0000, 32'hbfff_ffff});
    pending_ops.push_back('{32'h7f7f_ffff, 32'h0080_0000});
    pending_ops.push_back('{32'hff7f_ffff, 32'h0000_0001});
    pending_ops.push_back('{32'h0080_0000, 32'h7f7f_ffff});
    pending_ops.push_back('{32'h8000_0001, 32'h7f80_0000});
    pending_ops.push_back('{32'h7fff_ffff, 32'h7fff_ffff});
    pending_ops.push_back('{32'hffff_ffff, 32'h0000_0000});
    pending_ops.push_back('{32'h0000_0001, 32'hffff_ffff});
    pending_ops.push_back('{32'h3f00_0000, 32'h7e80_0000});
    pending_ops.push_back('{32'h7f00_0000, 32'h3e80_0000});
    pending_ops.push_back('{32'h5555_5555, 32'h2aaa_aaaa});
    pending_ops.push_back('{32'haaaa_aaaa, 32'hd555_5555});
    wait_for_drain();

    // Three hundred random transactions; wait until everything owed has come back.
    for (int i = 0; i < 300; i++) begin
      pending_ops.push_back(random_operands());
    end
    wait_for_drain();

    // Long receiver hold-off while the sender keeps offering, filling the pipe.
    for (int i = 0; i < 100; i++) begin
      pending_ops.push_back(random_operands());
    end
    long_stall_req = 1'b1;
    wait_for_drain();

    for (int i = 0; i < 750; i++) begin
      pending_ops.push_back(random_operands());
    end
    wait_for_drain();

    repeat (PipeLatency * 4) @(posedge clk);
    if (error_count == 0 && owed_quotients.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sfd_pkg.sv
rtl/sfd_if.sv
rtl/single_float_divider.sv
verif/sfd_tb_if.sv
verif/tb_single_float_divider.sv
